### src/lattice_run_tumble_step_macros.svh
// Assertion macros shared by the run-and-tumble step design.
`ifndef LATTICE_RUN_TUMBLE_STEP_MACROS_SVH
`define LATTICE_RUN_TUMBLE_STEP_MACROS_SVH

// Same-cycle implication, checked out of reset on clk_i.
`define LRTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset on clk_i.
`define LRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/lrts_pkg.sv
// Package with types, codes and lattice constants of the run-and-tumble step.
`timescale 1ns / 1ps
package lrts_pkg;

  // Lattice geometry and obstacle placement.
  localparam int unsigned GRID_WIDTH       = 10;
  localparam int unsigned GRID_HEIGHT      = 10;
  localparam int unsigned HOOK_COLUMN      = 5;
  localparam int unsigned HOOK_ROW         = 5;
  localparam int unsigned SYM_FIRST_COLUMN = 3;
  localparam int unsigned SYM_LAST_COLUMN  = 8;

  localparam logic [15:0] KEEP_RESET = 16'h8000;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_KEEP      = 3'd0,
    REG_THR_DIR0  = 3'd1,
    REG_THR_DIR1  = 3'd2,
    REG_THR_DIR2  = 3'd3,
    REG_THR_DIR3  = 3'd4,
    REG_OBSTACLE  = 3'd5
  } lrts_reg_e;

  // Item kinds.
  typedef enum logic [1:0] {
    KIND_PLACE = 2'd0,
    KIND_STEP  = 2'd1,
    KIND_CLEAR = 2'd2
  } lrts_kind_e;

  // Move codes.
  typedef enum logic [2:0] {
    MOVE_RIGHT = 3'd0,
    MOVE_LEFT  = 3'd1,
    MOVE_UP    = 3'd2,
    MOVE_DOWN  = 3'd3,
    MOVE_NONE  = 3'd4
  } lrts_move_e;

  // Obstacle layouts.
  typedef enum logic [1:0] {
    OBST_NONE       = 2'd0,
    OBST_LEFT_HOOK  = 2'd1,
    OBST_RIGHT_HOOK = 2'd2,
    OBST_SYM_HOOK   = 2'd3
  } lrts_obst_e;

  typedef struct packed {
    logic [15:0]      keep_threshold;
    logic [3:0][63:0] thresholds;
    logic [1:0]       obstacle_mode;
  } lrts_cfg_t;

  typedef struct packed {
    logic [3:0]         column;
    logic [3:0]         row;
    logic [1:0]         heading;
    logic signed [31:0] wraps;
  } lrts_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  start_x;
    logic [3:0]  start_y;
    logic [14:0] flip_draw;
    logic [1:0]  turn_offset;
    logic [14:0] move_draw;
    logic        measure;
  } lrts_item_t;

  typedef struct packed {
    logic [3:0]         pos_x;
    logic [3:0]         pos_y;
    logic [1:0]         direction;
    logic [2:0]         move_taken;
    logic signed [31:0] winding_count;
  } lrts_result_t;

endpackage

### src/lrts_if.sv
// Valid/ready channel interfaces for items, results and configuration writes.
`timescale 1ns / 1ps
interface lrts_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  start_x;
  logic [3:0]  start_y;
  logic [14:0] flip_draw;
  logic [1:0]  turn_offset;
  logic [14:0] move_draw;
  logic        measure;

  modport source (output valid, kind, start_x, start_y, flip_draw, turn_offset,
                  move_draw, measure, input ready);
  modport sink (input valid, kind, start_x, start_y, flip_draw, turn_offset,
                move_draw, measure, output ready);
endinterface

interface lrts_result_if;
  logic               valid;
  logic               ready;
  logic [3:0]         pos_x;
  logic [3:0]         pos_y;
  logic [1:0]         direction;
  logic [2:0]         move_taken;
  logic signed [31:0] winding_count;

  modport source (output valid, pos_x, pos_y, direction, move_taken, winding_count,
                  input ready);
  modport sink (input valid, pos_x, pos_y, direction, move_taken, winding_count,
                output ready);
endinterface

interface lrts_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/lrts_cfg_regs.sv
// Configuration register file: keep threshold, move thresholds, obstacle layout.
`timescale 1ns / 1ps
module lrts_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  lrts_cfg_if.sink          cfg_i,
  output lrts_pkg::lrts_cfg_t cfg_o
);
  import lrts_pkg::*;

  lrts_cfg_t cfg_q;
  lrts_cfg_t cfg_d;

  // Writes are always taken; indexes past the list are dropped.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_KEEP:     cfg_d.keep_threshold = cfg_i.data[15:0];
        REG_THR_DIR0: cfg_d.thresholds[0]  = cfg_i.data;
        REG_THR_DIR1: cfg_d.thresholds[1]  = cfg_i.data;
        REG_THR_DIR2: cfg_d.thresholds[2]  = cfg_i.data;
        REG_THR_DIR3: cfg_d.thresholds[3]  = cfg_i.data;
        REG_OBSTACLE: cfg_d.obstacle_mode  = cfg_i.data[1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.keep_threshold <= KEEP_RESET;
      cfg_q.thresholds     <= '0;
      cfg_q.obstacle_mode  <= OBST_NONE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/lrts_step_logic.sv
// Combinational step: tumble test, move choice, wall and wrap rules, winding count.
`timescale 1ns / 1ps
module lrts_step_logic (
  input  lrts_pkg::lrts_cfg_t    cfg_i,
  input  lrts_pkg::lrts_state_t  state_i,
  input  lrts_pkg::lrts_item_t   item_i,
  output lrts_pkg::lrts_state_t  state_o,
  output lrts_pkg::lrts_result_t result_o
);
  import lrts_pkg::*;

  // Positions are handled on 5 bits so that one past the edge still fits.
  localparam logic [4:0] X_PAST_EDGE = 5'(GRID_WIDTH + 1);
  localparam logic [4:0] Y_PAST_EDGE = 5'(GRID_HEIGHT + 1);
  localparam logic [4:0] X_LAST      = 5'(GRID_WIDTH);
  localparam logic [4:0] Y_LAST      = 5'(GRID_HEIGHT);
  localparam logic [4:0] HOOK_COL5   = 5'(HOOK_COLUMN);
  localparam logic [4:0] HOOK_COL5P  = 5'(HOOK_COLUMN + 1);
  localparam logic [4:0] HOOK_ROW5   = 5'(HOOK_ROW);
  localparam logic [4:0] HOOK_ROW5P  = 5'(HOOK_ROW + 1);
  localparam logic [4:0] SYM_FIRST5  = 5'(SYM_FIRST_COLUMN);
  localparam logic [4:0] SYM_LAST5   = 5'(SYM_LAST_COLUMN);
  localparam logic [3:0] X_MAX4      = 4'(GRID_WIDTH);
  localparam logic [3:0] Y_MAX4      = 4'(GRID_HEIGHT);
  localparam logic signed [31:0] WRAP_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] WRAP_MIN = 32'sh8000_0000;

  logic [1:0]  heading;
  logic [63:0] thr_row;
  logic [2:0]  move;
  logic [4:0]  x_cur;
  logic [4:0]  y_cur;
  logic [4:0]  x_nxt;
  logic [4:0]  y_nxt;
  logic        hook;
  logic        sym;
  logic        horiz_wall;
  logic        wrap_up;
  logic        wrap_down;

  // Tumble test and move choice against the current heading's thresholds.
  always_comb begin
    heading = state_i.heading;
    if ({1'b0, item_i.flip_draw} >= cfg_i.keep_threshold) begin
      heading = state_i.heading + item_i.turn_offset;
    end
    thr_row = cfg_i.thresholds[heading];
    move    = MOVE_NONE;
    for (int m = 3; m >= 0; m--) begin
      if ({1'b0, item_i.move_draw} < thr_row[16*m +: 16]) begin
        move = 3'(m);
      end
    end
  end

  // Obstacle layout decode.
  always_comb begin
    hook       = 1'b0;
    sym        = 1'b0;
    horiz_wall = 1'b0;
    unique case (cfg_i.obstacle_mode)
      OBST_NONE: begin
        horiz_wall = 1'b0;
      end
      OBST_LEFT_HOOK: begin
        hook       = 1'b1;
        horiz_wall = (x_cur <= HOOK_COL5);
      end
      OBST_RIGHT_HOOK: begin
        hook       = 1'b1;
        horiz_wall = (x_cur >= HOOK_COL5P);
      end
      OBST_SYM_HOOK: begin
        sym        = 1'b1;
        horiz_wall = (x_cur >= SYM_FIRST5) && (x_cur <= SYM_LAST5);
      end
      default: horiz_wall = 1'b0;
    endcase
  end

  // Apply the move: wall test first, then the edge rule.
  always_comb begin
    x_cur     = {1'b0, state_i.column};
    y_cur     = {1'b0, state_i.row};
    x_nxt     = x_cur;
    y_nxt     = y_cur;
    wrap_up   = 1'b0;
    wrap_down = 1'b0;
    unique case (move)
      MOVE_RIGHT: begin
        x_nxt = x_cur + 5'd1;
        if (hook && (x_nxt == X_PAST_EDGE) && (y_cur <= HOOK_ROW5)) begin
          x_nxt = x_cur;
        end else if (sym && (x_nxt == HOOK_COL5P) && (y_cur <= HOOK_ROW5)) begin
          x_nxt = x_cur;
        end else if (x_nxt == X_PAST_EDGE) begin
          x_nxt   = 5'd1;
          wrap_up = 1'b1;
        end
      end
      MOVE_LEFT: begin
        x_nxt = x_cur - 5'd1;
        if (hook && (x_nxt == 5'd0) && (y_cur <= HOOK_ROW5)) begin
          x_nxt = x_cur;
        end else if (sym && (x_nxt == HOOK_COL5) && (y_cur <= HOOK_ROW5)) begin
          x_nxt = x_cur;
        end else if (x_nxt == 5'd0) begin
          x_nxt     = X_LAST;
          wrap_down = 1'b1;
        end
      end
      MOVE_UP: begin
        y_nxt = y_cur + 5'd1;
        if (horiz_wall && (y_nxt == HOOK_ROW5P)) begin
          y_nxt = y_cur;
        end else if (y_nxt == Y_PAST_EDGE) begin
          y_nxt = Y_LAST;
        end
      end
      MOVE_DOWN: begin
        y_nxt = y_cur - 5'd1;
        if (horiz_wall && (y_nxt == HOOK_ROW5)) begin
          y_nxt = y_cur;
        end else if (y_nxt == 5'd0) begin
          y_nxt = 5'd1;
        end
      end
      default: begin
        x_nxt = x_cur;
      end
    endcase
  end

  // Next state and result word by item kind.
  always_comb begin
    state_o             = state_i;
    result_o.move_taken = MOVE_NONE;
    case (item_i.kind)
      KIND_PLACE: begin
        if (item_i.start_x == 4'd0) begin
          state_o.column = 4'd1;
        end else if (item_i.start_x > X_MAX4) begin
          state_o.column = X_MAX4;
        end else begin
          state_o.column = item_i.start_x;
        end
        if (item_i.start_y == 4'd0) begin
          state_o.row = 4'd1;
        end else if (item_i.start_y > Y_MAX4) begin
          state_o.row = Y_MAX4;
        end else begin
          state_o.row = item_i.start_y;
        end
      end
      KIND_STEP: begin
        state_o.heading     = heading;
        state_o.column      = x_nxt[3:0];
        state_o.row         = y_nxt[3:0];
        result_o.move_taken = move;
        if (item_i.measure && wrap_up && (state_i.wraps != WRAP_MAX)) begin
          state_o.wraps = state_i.wraps + 32'sd1;
        end else if (item_i.measure && wrap_down && (state_i.wraps != WRAP_MIN)) begin
          state_o.wraps = state_i.wraps - 32'sd1;
        end
      end
      KIND_CLEAR: begin
        state_o.wraps = '0;
      end
      default: begin
        state_o = state_i;
      end
    endcase
    result_o.pos_x         = state_o.column;
    result_o.pos_y         = state_o.row;
    result_o.direction     = state_o.heading;
    result_o.winding_count = state_o.wraps;
  end

endmodule

### src/lattice_run_tumble_step.sv
// Top level of the run-and-tumble lattice step: input stage, state, result stage.
// A word passes through the input register, then the result register, before its
// result is offered on the result channel.
// Throughput: one word per cycle while results are taken; the particle state register
// is updated in the same cycle that a word moves from input to result register.
// Reset clears both stages, puts the particle at column 1, row 1, heading 0,
// winding count 0, and returns the configuration registers to their defaults.
`timescale 1ns / 1ps
`include "lattice_run_tumble_step_macros.svh"
module lattice_run_tumble_step (
  input  logic       clk_i,
  input  logic       rst_ni,
  lrts_item_if.sink  item_i,
  lrts_result_if.source result_o,
  lrts_cfg_if.sink   cfg_i
);
  import lrts_pkg::*;

  localparam logic [3:0] GRID_W4 = 4'(GRID_WIDTH);
  localparam logic [3:0] GRID_H4 = 4'(GRID_HEIGHT);

  lrts_cfg_t    cfg;
  lrts_item_t   item_q;
  logic         item_vld_q;
  lrts_state_t  state_q;
  lrts_state_t  state_d;
  lrts_result_t res_d;
  lrts_result_t res_q;
  logic         res_vld_q;
  logic         advance;

  // Configuration registers.
  lrts_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Step logic between the input register and the result register.
  lrts_step_logic u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // A word moves forward when the result register is free or being emptied.
  assign advance      = item_vld_q && (!res_vld_q || result_o.ready);
  assign item_i.ready = !item_vld_q || advance;

  // Input stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (item_i.ready) begin
      item_vld_q <= item_i.valid;
    end
  end

  // Input stage payload.
  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      item_q.kind        <= item_i.kind;
      item_q.start_x     <= item_i.start_x;
      item_q.start_y     <= item_i.start_y;
      item_q.flip_draw   <= item_i.flip_draw;
      item_q.turn_offset <= item_i.turn_offset;
      item_q.move_draw   <= item_i.move_draw;
      item_q.measure     <= item_i.measure;
    end
  end

  // Particle state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.column  <= 4'd1;
      state_q.row     <= 4'd1;
      state_q.heading <= 2'd0;
      state_q.wraps   <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  // Result stage payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid         = res_vld_q;
  assign result_o.pos_x         = res_q.pos_x;
  assign result_o.pos_y         = res_q.pos_y;
  assign result_o.direction     = res_q.direction;
  assign result_o.move_taken    = res_q.move_taken;
  assign result_o.winding_count = res_q.winding_count;

  // Checks on the datapath and stage handoff.
  `LRTS_ASSERT_NEXT(a_advance_fills_result, advance, res_vld_q, "result stage not filled")
  `LRTS_ASSERT_NOW(a_column_range, 1'b1,
    (state_q.column >= 4'd1) && (state_q.column <= GRID_W4), "column out of range")
  `LRTS_ASSERT_NOW(a_row_range, 1'b1,
    (state_q.row >= 4'd1) && (state_q.row <= GRID_H4), "row out of range")
  `LRTS_ASSERT_NEXT(a_non_step_no_move, advance && (item_q.kind != KIND_STEP),
    res_q.move_taken == MOVE_NONE, "move reported for a non-step word")
  `LRTS_ASSERT_NEXT(a_wrap_by_one, advance && (item_q.kind == KIND_STEP),
    (state_q.wraps == $past(state_q.wraps)) ||
    (state_q.wraps == $past(state_q.wraps) + 32'sd1) ||
    (state_q.wraps == $past(state_q.wraps) - 32'sd1), "winding count jumped")

endmodule

### tb/testbench.sv
// Self-checking testbench for the run-and-tumble lattice step block.
`timescale 1ns / 1ps
module testbench;
  import lrts_pkg::*;

  // Index and kind codes that the block must accept and ignore.
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  localparam logic signed [31:0] WIND_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] WIND_MIN = 32'sh8000_0000;

  // Even four-way split of the draw range: right, left, up, down, then none.
  localparam logic [63:0] EVEN_SPLIT = {16'd32767, 16'd24576, 16'd16384, 16'd8192};

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 200;
  localparam int DRAIN_CYCLES = 1000;

  typedef struct {
    int           preset;
    lrts_item_t   item;
    bit           typed;
    lrts_result_t want;
  } opening_row_t;

  logic clk;
  logic rst_n;

  lrts_item_if   item_bus ();
  lrts_result_if res_bus ();
  lrts_cfg_if    cfg_bus ();

  lattice_run_tumble_step uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (item_bus),
    .result_o(res_bus),
    .cfg_i   (cfg_bus)
  );

  // Predicted particle state and register copy.
  logic [3:0]         part_col;
  logic [3:0]         part_row;
  logic [1:0]         part_head;
  logic signed [31:0] part_wind;
  lrts_cfg_t          model_cfg;

  lrts_result_t pending_results[$];
  opening_row_t opening_rows[$];
  lrts_cfg_t    presets[1:4];

  int idle_style;
  int error_count;
  int items_sent;
  int results_checked;
  int cfg_writes;
  int move_hits[5];

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int next_gap();
    return (idle_style != 0) ? 0 : int'($urandom_range(12, 0));
  endfunction

  function automatic void bump_winding(bit up, bit meas);
    if (meas) begin
      if (up && part_wind != WIND_MAX) part_wind = part_wind + 1;
      else if (!up && part_wind != WIND_MIN) part_wind = part_wind - 1;
    end
  endfunction

  // True when the horizontal wall of the current layout sits over column x.
  function automatic bit horiz_blocked(int x);
    int hc = HOOK_COLUMN;
    int sf = SYM_FIRST_COLUMN;
    int sl = SYM_LAST_COLUMN;
    case (model_cfg.obstacle_mode)
      OBST_LEFT_HOOK:  return x <= hc;
      OBST_RIGHT_HOOK: return x >= hc + 1;
      OBST_SYM_HOOK:   return x >= sf && x <= sl;
      default:         return 1'b0;
    endcase
  endfunction

  // Advance the predicted particle by one word and return the expected result.
  function automatic lrts_result_t predict_particle(lrts_item_t it);
    lrts_result_t r;
    lrts_move_e   mv;
    logic [15:0]  t;
    int x, y, m;
    int gw = GRID_WIDTH;
    int gh = GRID_HEIGHT;
    int hc = HOOK_COLUMN;
    int hr = HOOK_ROW;
    bit hook, sym;
    mv = MOVE_NONE;
    if (it.kind == KIND_PLACE) begin
      x = it.start_x;
      y = it.start_y;
      part_col = (x < 1) ? 4'd1 : (x > gw) ? 4'(gw) : 4'(x);
      part_row = (y < 1) ? 4'd1 : (y > gh) ? 4'(gh) : 4'(y);
    end else if (it.kind == KIND_STEP) begin
      if ({1'b0, it.flip_draw} >= model_cfg.keep_threshold) begin
        part_head = part_head + it.turn_offset;
      end
      // First threshold above the draw wins, in the order right, left, up, down.
      for (m = 0; m < 4; m++) begin
        t = model_cfg.thresholds[part_head][16*m +: 16];
        if (mv == MOVE_NONE && {1'b0, it.move_draw} < t) mv = lrts_move_e'(m);
      end
      x = part_col;
      y = part_row;
      hook = (model_cfg.obstacle_mode == OBST_LEFT_HOOK) ||
             (model_cfg.obstacle_mode == OBST_RIGHT_HOOK);
      sym = (model_cfg.obstacle_mode == OBST_SYM_HOOK);
      case (mv)
        MOVE_RIGHT: begin
          x++;
          if (hook && x == gw + 1 && y <= hr) x--;
          else if (sym && x == hc + 1 && y <= hr) x--;
          else if (x == gw + 1) begin
            x = 1;
            bump_winding(1'b1, it.measure);
          end
        end
        MOVE_LEFT: begin
          x--;
          if (hook && x == 0 && y <= hr) x++;
          else if (sym && x == hc && y <= hr) x++;
          else if (x == 0) begin
            x = gw;
            bump_winding(1'b0, it.measure);
          end
        end
        MOVE_UP: begin
          y++;
          if (horiz_blocked(x) && y == hr + 1) y--;
          else if (y == gh + 1) y = gh;
        end
        MOVE_DOWN: begin
          y--;
          if (horiz_blocked(x) && y == hr) y++;
          else if (y == 0) y = 1;
        end
        default: ;
      endcase
      part_col = 4'(x);
      part_row = 4'(y);
    end else if (it.kind == KIND_CLEAR) begin
      part_wind = '0;
    end
    r.pos_x         = part_col;
    r.pos_y         = part_row;
    r.direction     = part_head;
    r.move_taken    = mv;
    r.winding_count = part_wind;
    return r;
  endfunction

  function automatic void note_cfg_write(logic [2:0] idx, logic [63:0] d);
    case (idx)
      REG_KEEP:     model_cfg.keep_threshold = d[15:0];
      REG_THR_DIR0: model_cfg.thresholds[0] = d;
      REG_THR_DIR1: model_cfg.thresholds[1] = d;
      REG_THR_DIR2: model_cfg.thresholds[2] = d;
      REG_THR_DIR3: model_cfg.thresholds[3] = d;
      REG_OBSTACLE: model_cfg.obstacle_mode = d[1:0];
      default: ;
    endcase
  endfunction

  function automatic lrts_item_t place_word(int x, int y);
    lrts_item_t it;
    it = lrts_item_t'({$urandom, $urandom});
    it.kind    = KIND_PLACE;
    it.start_x = 4'(x);
    it.start_y = 4'(y);
    return it;
  endfunction

  function automatic lrts_item_t step_word(int flip, int turn, int draw, int meas);
    lrts_item_t it;
    it = lrts_item_t'({$urandom, $urandom});
    it.kind        = KIND_STEP;
    it.flip_draw   = 15'(flip);
    it.turn_offset = 2'(turn);
    it.move_draw   = 15'(draw);
    it.measure     = 1'(meas);
    return it;
  endfunction

  function automatic lrts_result_t idle_result(int x, int y);
    lrts_result_t r;
    r.pos_x         = 4'(x);
    r.pos_y         = 4'(y);
    r.direction     = 2'd0;
    r.move_taken    = MOVE_NONE;
    r.winding_count = '0;
    return r;
  endfunction

  // Mostly steps with random draws; placements, clears and the unused kind mixed in.
  function automatic lrts_item_t rand_item();
    lrts_item_t it;
    int pick;
    it = lrts_item_t'({$urandom, $urandom});
    pick = $urandom_range(99, 0);
    if (pick < 5) it.kind = KIND_PLACE;
    else if (pick < 8) it.kind = KIND_CLEAR;
    else if (pick < 11) it.kind = KIND_UNUSED;
    else it.kind = KIND_STEP;
    return it;
  endfunction

  function automatic logic [63:0] rand_thresholds();
    logic [15:0] a, b, c, d;
    case ($urandom_range(3, 0))
      0, 1: begin
        // Well-formed cumulative thresholds.
        a = 16'($urandom_range(32768, 0));
        b = 16'($urandom_range(32768, a));
        c = 16'($urandom_range(32768, b));
        d = 16'($urandom_range(32768, c));
        return {d, c, b, a};
      end
      2:       return {$urandom, $urandom};
      default: return ($urandom_range(1, 0) != 0) ? '1 : '0;
    endcase
  endfunction

  function automatic lrts_cfg_t draw_config(int phase);
    lrts_cfg_t c;
    int h;
    case (phase)
      0:       c.keep_threshold = 16'd0;
      1:       c.keep_threshold = 16'hFFFF;
      2:       c.keep_threshold = KEEP_RESET;
      default: c.keep_threshold = 16'($urandom_range(32768, 0));
    endcase
    for (h = 0; h < 4; h++) c.thresholds[h] = rand_thresholds();
    c.obstacle_mode = 2'(phase % 4);
    return c;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] d);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      cfg_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= d;
    do @(posedge clk); while (!cfg_bus.ready);
    note_cfg_write(idx, d);
    cfg_writes++;
  endtask

  // Let the block go idle, then rewrite every register.
  task automatic load_config(input lrts_cfg_t c);
    int h;
    item_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    write_reg(REG_KEEP, {32'($urandom), 16'($urandom), c.keep_threshold});
    for (h = 0; h < 4; h++) write_reg(3'(REG_THR_DIR0 + h), c.thresholds[h]);
    write_reg(REG_SPARE_LO, {$urandom, $urandom});
    write_reg(REG_SPARE_HI, {$urandom, $urandom});
    write_reg(REG_OBSTACLE, {32'($urandom), 30'($urandom), c.obstacle_mode});
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_item(input lrts_item_t it, input bit typed, input lrts_result_t want);
    int gap;
    lrts_result_t pred;
    gap = next_gap();
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid       <= 1'b1;
    item_bus.kind        <= it.kind;
    item_bus.start_x     <= it.start_x;
    item_bus.start_y     <= it.start_y;
    item_bus.flip_draw   <= it.flip_draw;
    item_bus.turn_offset <= it.turn_offset;
    item_bus.move_draw   <= it.move_draw;
    item_bus.measure     <= it.measure;
    do @(posedge clk); while (!item_bus.ready);
    pred = predict_particle(it);
    pending_results.push_back(typed ? want : pred);
    items_sent++;
  endtask

  task automatic add_row(input int preset, input lrts_item_t it, input bit typed,
                         input lrts_result_t want);
    opening_row_t row;
    row.preset = preset;
    row.item   = it;
    row.typed  = typed;
    row.want   = want;
    opening_rows.push_back(row);
  endtask

  // Result sink with random stalls.
  initial begin
    int stall;
    res_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = next_gap();
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk); while (!res_bus.valid);
    end
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin : result_check
    lrts_result_t got, want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      got.pos_x         = res_bus.pos_x;
      got.pos_y         = res_bus.pos_y;
      got.direction     = res_bus.direction;
      got.move_taken    = res_bus.move_taken;
      got.winding_count = res_bus.winding_count;
      if (pending_results.size() == 0) begin
        $error("result word arrived with no prediction pending");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.move_taken < 5) move_hits[got.move_taken]++;
        if (got.pos_x !== want.pos_x) begin
          $error("pos_x: expected %0d, got %0d", want.pos_x, got.pos_x);
          error_count++;
        end
        if (got.pos_y !== want.pos_y) begin
          $error("pos_y: expected %0d, got %0d", want.pos_y, got.pos_y);
          error_count++;
        end
        if (got.direction !== want.direction) begin
          $error("direction: expected %0d, got %0d", want.direction, got.direction);
          error_count++;
        end
        if (got.move_taken !== want.move_taken) begin
          $error("move_taken: expected %0d, got %0d", want.move_taken, got.move_taken);
          error_count++;
        end
        if (got.winding_count !== want.winding_count) begin
          $error("winding_count: expected %0d, got %0d", want.winding_count,
                 got.winding_count);
          error_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed rows, random phases, drain.
  initial begin
    lrts_item_t   spare_kind;
    lrts_result_t none_res;
    int phase, n, w;

    rst_n                = 1'b0;
    idle_style           = 0;
    item_bus.valid       = 1'b0;
    item_bus.kind        = KIND_PLACE;
    item_bus.start_x     = '0;
    item_bus.start_y     = '0;
    item_bus.flip_draw   = '0;
    item_bus.turn_offset = '0;
    item_bus.move_draw   = '0;
    item_bus.measure     = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = REG_KEEP;
    cfg_bus.data         = '0;

    part_col  = 4'd1;
    part_row  = 4'd1;
    part_head = 2'd0;
    part_wind = '0;
    model_cfg.keep_threshold = KEEP_RESET;
    model_cfg.thresholds     = '0;
    model_cfg.obstacle_mode  = OBST_NONE;

    presets[1].keep_threshold = 16'd16384;
    presets[1].thresholds     = {4{EVEN_SPLIT}};
    presets[1].obstacle_mode  = OBST_NONE;
    presets[2].keep_threshold = 16'd0;
    presets[2].thresholds     = {4{16'hFFFF, 16'h8000, 16'd200, 16'd100}};
    presets[2].obstacle_mode  = OBST_LEFT_HOOK;
    presets[3].keep_threshold = 16'hFFFF;
    presets[3].thresholds     = {4{16'hFFFF, 16'd0, 16'd20000, 16'd100}};
    presets[3].obstacle_mode  = OBST_RIGHT_HOOK;
    presets[4].keep_threshold = KEEP_RESET;
    presets[4].thresholds     = {4{EVEN_SPLIT}};
    presets[4].obstacle_mode  = OBST_SYM_HOOK;

    none_res   = '0;
    spare_kind = '1;

    // Reset defaults: nothing moves, placement clamps at both ends.
    add_row(0, lrts_item_t'({KIND_CLEAR, 41'd0}), 1'b1, idle_result(1, 1));
    add_row(0, place_word(0, 15), 1'b1, idle_result(1, 10));
    add_row(0, place_word(15, 0), 1'b1, idle_result(10, 1));
    add_row(0, spare_kind, 1'b1, idle_result(10, 1));
    add_row(0, step_word(32767, 3, 0, 1), 1'b1, idle_result(10, 1));
    // Open lattice: wrap both ways, tumble at the keep threshold, top wall, no move.
    add_row(1, step_word(0, 3, 0, 1), 1'b0, none_res);
    add_row(0, step_word(16383, 2, 8192, 1), 1'b0, none_res);
    add_row(0, step_word(16384, 1, 16384, 0), 1'b0, none_res);
    add_row(0, place_word(5, 10), 1'b0, none_res);
    add_row(0, step_word(0, 0, 16384, 1), 1'b0, none_res);
    add_row(0, step_word(0, 0, 32767, 1), 1'b0, none_res);
    // Left hook: edge wall below the hook row, shelf over the left columns.
    add_row(2, place_word(10, 3), 1'b0, none_res);
    add_row(0, step_word(5, 0, 50, 1), 1'b0, none_res);
    add_row(0, place_word(1, 5), 1'b0, none_res);
    add_row(0, step_word(9, 0, 300, 1), 1'b0, none_res);
    // Right hook with thresholds out of order and a keep threshold above the range.
    add_row(3, place_word(1, 4), 1'b0, none_res);
    add_row(0, step_word(32767, 3, 500, 1), 1'b0, none_res);
    add_row(0, place_word(8, 6), 1'b0, none_res);
    add_row(0, step_word(0, 0, 30000, 1), 1'b0, none_res);
    // Symmetric hook: center wall from both sides, then the shelf from above.
    add_row(4, place_word(5, 3), 1'b0, none_res);
    add_row(0, step_word(0, 0, 0, 1), 1'b0, none_res);
    add_row(0, place_word(6, 3), 1'b0, none_res);
    add_row(0, step_word(0, 0, 8192, 1), 1'b0, none_res);
    add_row(0, place_word(3, 6), 1'b0, none_res);
    add_row(0, step_word(0, 0, 24576, 1), 1'b0, none_res);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[i]) begin
      if (opening_rows[i].preset != 0) load_config(presets[opening_rows[i].preset]);
      send_item(opening_rows[i].item, opening_rows[i].typed, opening_rows[i].want);
    end

    // Random phases, each with its own settings; every third phase runs without gaps.
    for (phase = 0; phase < PHASES; phase++) begin
      idle_style = 0;
      load_config(draw_config(phase));
      idle_style = (phase % 3 == 1) ? 1 : 0;
      for (n = 0; n < PHASE_ITEMS; n++) send_item(rand_item(), 1'b0, none_res);
    end

    // Drain the remaining results.
    idle_style = 0;
    item_bus.valid <= 1'b0;
    for (w = 0; w < DRAIN_CYCLES && pending_results.size() != 0; w++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d predicted results never arrived", pending_results.size());
      error_count++;
    end

    $display("Sent %0d item words, checked %0d results, made %0d register writes.",
             items_sent, results_checked, cfg_writes);
    $display("Moves seen: right %0d, left %0d, up %0d, down %0d, none %0d.",
             move_hits[0], move_hits[1], move_hits[2], move_hits[3], move_hits[4]);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
